/* src/ssnf_pkg.sv */
// shared types, constants and segment lookup for the seven-segment formatter
`default_nettype none
package ssnf_pkg;

  localparam int VAL_W       = 27;
  localparam int QUO_W       = 24;
  localparam int DIGIT_COUNT = 8;
  localparam int IDX_W       = $clog2(DIGIT_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_COUNT  = 7;

  localparam logic [7:0] CMD_INT_BASE  = 8'h97;
  localparam logic [7:0] CMD_REAL_BASE = 8'h9A;
  localparam logic [7:0] SEG_MINUS     = 8'h01;
  localparam logic [7:0] SEG_BLANK     = 8'h00;
  localparam logic [7:0] SEG_ERROR     = 8'h6F;
  localparam logic [7:0] SEG_DP        = 8'h80;

  localparam logic [VAL_W-1:0] LIM_INT = VAL_W'(999);
  localparam logic [VAL_W-1:0] LIM_E4  = VAL_W'(10000);
  localparam logic [VAL_W-1:0] LIM_E5  = VAL_W'(100000);
  localparam logic [VAL_W-1:0] LIM_E6  = VAL_W'(1000000);

  // exact x/10 for any 32-bit x: (x * 0xCCCCCCCD) >> 35
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = VAL_W + 32;

  // classified item from the front end
  typedef struct packed {
    logic             real_mode;
    logic             neg;
    logic             err;
    logic [2:0]       scale;      // [0] a>=1e4, [1] a>=1e5, [2] a>=1e6
    logic [VAL_W-1:0] mag;
  } cls_t;

  // finished digit record, digit[0] is display position 4
  typedef struct packed {
    logic             real_mode;
    logic             neg;
    logic             err;
    logic [2:0]       scale;
    logic [3:0][3:0]  digit;
  } digs_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h30;
      4'd2:    s = 8'h6D;
      4'd3:    s = 8'h79;
      4'd4:    s = 8'h33;
      4'd5:    s = 8'h5B;
      4'd6:    s = 8'h5F;
      4'd7:    s = 8'h70;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h7B;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

/* src/ssnf_front.sv */
// front end: accepts items, takes the magnitude and classifies range and mode
`default_nettype none
module ssnf_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         req_type,
  input  wire logic [ssnf_pkg::VAL_W-1:0]   value,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output ssnf_pkg::cls_t                    q_data
);

  logic                         valid_r;
  ssnf_pkg::cls_t               cls_r;
  ssnf_pkg::cls_t               cls_nxt;
  logic [ssnf_pkg::VAL_W-1:0]   mag;

  always_comb begin
    mag = value[ssnf_pkg::VAL_W-1] ? (~value + ssnf_pkg::VAL_W'(1)) : value;
    cls_nxt.real_mode = req_type;
    cls_nxt.neg       = req_type & value[ssnf_pkg::VAL_W-1];
    cls_nxt.err       = ~req_type &
                        (value[ssnf_pkg::VAL_W-1] | (value > ssnf_pkg::LIM_INT));
    cls_nxt.mag       = req_type ? mag : value;
    if (req_type) begin
      cls_nxt.scale = {mag >= ssnf_pkg::LIM_E6, mag >= ssnf_pkg::LIM_E5,
                       mag >= ssnf_pkg::LIM_E4};
    end else begin
      cls_nxt.scale = 3'b000;
    end
  end

  assign in_ready = ~valid_r | q_ready;
  assign q_valid  = valid_r;
  assign q_data   = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      cls_r <= cls_nxt;
    end
  end

endmodule
`default_nettype wire

/* src/ssnf_queue.sv */
// short queue of classified items between front and back end
`default_nettype none
module ssnf_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire ssnf_pkg::cls_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output ssnf_pkg::cls_t       pop_data
);

  localparam int AW = (ssnf_pkg::QUEUE_DEPTH > 1) ? $clog2(ssnf_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(ssnf_pkg::QUEUE_DEPTH + 1);

  ssnf_pkg::cls_t  mem_r [ssnf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CW'(ssnf_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(ssnf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(ssnf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (!do_push && do_pop) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* src/ssnf_digits.sv */
// back end digit unit: one shared divide-by-ten step per cycle, scaling then digits
`default_nettype none
module ssnf_digits (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ssnf_pkg::cls_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_take,
  output ssnf_pkg::digs_t      out_data
);

  localparam int SW = $clog2(ssnf_pkg::STEP_COUNT);

  logic                           busy_r;
  logic                           done_r;
  logic [SW-1:0]                  step_r;
  logic [ssnf_pkg::VAL_W-1:0]     x_r;
  ssnf_pkg::digs_t                rec_r;
  logic [ssnf_pkg::PROD_W-1:0]    prod;
  logic [ssnf_pkg::QUO_W-1:0]     quo;
  logic [ssnf_pkg::VAL_W-1:0]     rem_full;
  logic [1:0]                     dig_idx;
  logic                           load;
  logic                           last_step;

  // x / 10 and x mod 10
  always_comb begin
    prod     = ssnf_pkg::PROD_W'(x_r) * ssnf_pkg::PROD_W'(ssnf_pkg::RECIP10);
    quo      = prod[ssnf_pkg::RECIP_SHIFT +: ssnf_pkg::QUO_W];
    rem_full = x_r - ssnf_pkg::VAL_W'(quo) * ssnf_pkg::VAL_W'(10);
    dig_idx  = 2'(SW'(ssnf_pkg::STEP_COUNT - 1) - step_r);
  end

  assign in_ready  = ~busy_r & (~done_r | out_take);
  assign load      = in_valid & in_ready;
  assign last_step = (step_r == SW'(ssnf_pkg::STEP_COUNT - 1));
  assign out_valid = done_r;
  assign out_data  = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (out_take) begin
        done_r <= 1'b0;
      end
      if (load) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + SW'(1);
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_r             <= in_data.mag;
      rec_r.real_mode <= in_data.real_mode;
      rec_r.neg       <= in_data.neg;
      rec_r.err       <= in_data.err;
      rec_r.scale     <= in_data.scale;
    end else if (busy_r) begin
      // first three steps range-scale, the rest peel off ones, tens, hundreds, thousands
      if (step_r < SW'(3)) begin
        if (rec_r.scale[step_r[1:0]]) begin
          x_r <= ssnf_pkg::VAL_W'(quo);
        end
      end else begin
        rec_r.digit[dig_idx] <= rem_full[3:0];
        x_r                  <= ssnf_pkg::VAL_W'(quo);
      end
    end
  end

endmodule
`default_nettype wire

/* src/ssnf_emit.sv */
// back end write sequencer: eight command and segment writes per item into an output register
`default_nettype none
module ssnf_emit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             dig_valid,
  output logic                  dig_take,
  input  wire ssnf_pkg::digs_t  dig_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_cmd,
  output logic [7:0]            out_seg,
  output logic                  out_last
);

  logic                        valid_r;
  logic [ssnf_pkg::IDX_W-1:0]  idx_r;
  logic [ssnf_pkg::IDX_W-1:0]  idx_nxt;
  ssnf_pkg::digs_t             rec_r;
  ssnf_pkg::digs_t             src;
  logic [7:0]                  cmd_r;
  logic [7:0]                  cmd_nxt;
  logic [7:0]                  seg_r;
  logic [7:0]                  seg_nxt;
  logic                        last_r;
  logic                        take;
  logic                        finishing;
  logic [1:0]                  pos;
  logic [7:0]                  dig_seg;
  logic                        dp_here;

  assign take      = valid_r & out_ready;
  assign finishing = ~valid_r | (take & last_r);
  assign dig_take  = finishing & dig_valid;

  always_comb begin
    src     = dig_take ? dig_data : rec_r;
    idx_nxt = dig_take ? '0 : idx_r + ssnf_pkg::IDX_W'(1);
    pos     = 2'(idx_nxt - ssnf_pkg::IDX_W'(4));
    dig_seg = ssnf_pkg::seg_of(src.digit[pos]);
    // decimal point lands on the first digit whose range was not exceeded
    if (!src.scale[0]) begin
      dp_here = (idx_nxt == ssnf_pkg::IDX_W'(4));
    end else if (!src.scale[1]) begin
      dp_here = (idx_nxt == ssnf_pkg::IDX_W'(5));
    end else if (!src.scale[2]) begin
      dp_here = (idx_nxt == ssnf_pkg::IDX_W'(6));
    end else begin
      dp_here = 1'b0;
    end
    if (src.real_mode) begin
      cmd_nxt = ssnf_pkg::CMD_REAL_BASE - 8'(idx_nxt);
      if (idx_nxt < ssnf_pkg::IDX_W'(3)) begin
        seg_nxt = ssnf_pkg::SEG_BLANK;
      end else if (idx_nxt == ssnf_pkg::IDX_W'(3)) begin
        seg_nxt = src.neg ? ssnf_pkg::SEG_MINUS : ssnf_pkg::SEG_BLANK;
      end else begin
        seg_nxt = dig_seg | (dp_here ? ssnf_pkg::SEG_DP : ssnf_pkg::SEG_BLANK);
      end
    end else begin
      cmd_nxt = ssnf_pkg::CMD_INT_BASE - 8'(idx_nxt);
      if (idx_nxt < ssnf_pkg::IDX_W'(5)) begin
        seg_nxt = ssnf_pkg::SEG_BLANK;
      end else begin
        seg_nxt = src.err ? ssnf_pkg::SEG_ERROR : dig_seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dig_take) begin
      valid_r <= 1'b1;
    end else if (finishing) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_take || take) begin
      rec_r  <= src;
      idx_r  <= idx_nxt;
      cmd_r  <= cmd_nxt;
      seg_r  <= seg_nxt;
      last_r <= (idx_nxt == ssnf_pkg::IDX_W'(ssnf_pkg::DIGIT_COUNT - 1));
    end
  end

  assign out_valid = valid_r;
  assign out_cmd   = cmd_r;
  assign out_seg   = seg_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire

/* src/seven_segment_number_formatter.sv */
// Turns a number into eight digit writes for an 8-digit seven-segment driver.
// Input channel in_*: in_tdata[26:0] is value (signed), in_tuser is req_type
// (0 integer 0..999 in the three rightmost digits, 1 signed real in thousandths).
// Output channel out_*: each item gives eight writes, digit position 0 first;
// out_tdata[7:0] is the driver command byte, out_tdata[15:8] the segment byte
// (bit 15 is the decimal point), out_tlast marks the eighth write.
// Each item passes the front register, the queue and the digit unit to the output.
// Throughput is set by the eight writes on the output; the digit unit runs its
// scaling and digit steps on its shared divide-by-ten multiplier and works on
// the next item while the current one is written out.
// A front register and a 2-entry queue take new items while the output is stalled;
// when out_tready is low the current write holds and in_tready drops once the
// queue fills. Synchronous reset clears all handshake state: no write pending.
`default_nettype none
module seven_segment_number_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [26:0] value, [31:27] zero
  input  wire logic        in_tuser,   // [0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] digit_command, [15:8] segment_bits
  output logic             out_tlast
);

  logic            q_in_valid;
  logic            q_in_ready;
  ssnf_pkg::cls_t  q_in_data;
  logic            q_out_valid;
  logic            q_out_ready;
  ssnf_pkg::cls_t  q_out_data;
  logic            dig_valid;
  logic            dig_take;
  ssnf_pkg::digs_t dig_data;
  logic [7:0]      cmd;
  logic [7:0]      seg;

  ssnf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .req_type (in_tuser),
    .value    (in_tdata[ssnf_pkg::VAL_W-1:0]),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  ssnf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_data  (q_in_data),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_data   (q_out_data)
  );

  ssnf_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_out_valid),
    .in_ready  (q_out_ready),
    .in_data   (q_out_data),
    .out_valid (dig_valid),
    .out_take  (dig_take),
    .out_data  (dig_data)
  );

  ssnf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .dig_valid (dig_valid),
    .dig_take  (dig_take),
    .dig_data  (dig_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_cmd   (cmd),
    .out_seg   (seg),
    .out_last  (out_tlast)
  );

  assign out_tdata = {seg, cmd};

endmodule
`default_nettype wire

/* src/ssnf_checker.sv */
// port-level checks for the seven-segment formatter and their binding
`default_nettype none
module ssnf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tready ^ (^in_tdata) ^ in_tuser;

  // stalled write holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled write changed");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("write pending after reset");

  // inside a run the next write follows at once, one digit position on
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[7:0] == $past(out_tdata[7:0]) - 8'd1))
    else $error("run of writes broken");

  // the last write goes to the last digit, and real mode's first three digits are blank
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == 8'h90 || out_tdata[7:0] == 8'h93)
    else $error("last flag on wrong digit");

  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] == 8'h9A || out_tdata[7:0] == 8'h99 ||
      out_tdata[7:0] == 8'h98) |-> out_tdata[15:8] == 8'h00)
    else $error("leading digit not blank");

endmodule

bind seven_segment_number_formatter ssnf_checker u_ssnf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
